// File: hw/rtl/lc2u_pkg.sv
// Shared types, control codes and glyph lookup functions for the text-to-UTF-8 converter.
package lc2u_pkg;

  localparam int unsigned RunMax = 6;

  // One decoded run: up to six UTF-8 bytes, first byte in b[0].
  typedef struct packed {
    logic [RunMax-1:0][7:0] b;
    logic [2:0]             cnt;
  } run_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ACCENT = 8'h16;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_CURSOR = 8'h1f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_GRAVE  = 8'h60;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] UTF_C3    = 8'hc3;

  localparam run_t RUN_NONE = '{b: '0, cnt: 3'd0};

  function automatic run_t run1(input logic [7:0] a);
    run_t r;
    r     = RUN_NONE;
    r.b[0] = a;
    r.cnt = 3'd1;
    return r;
  endfunction

  function automatic run_t run2(input logic [7:0] a, input logic [7:0] z);
    run_t r;
    r      = RUN_NONE;
    r.b[0] = a;
    r.b[1] = z;
    r.cnt  = 3'd2;
    return r;
  endfunction

  function automatic run_t run3(input logic [7:0] a, input logic [7:0] m,
                                input logic [7:0] z);
    run_t r;
    r      = RUN_NONE;
    r.b[0] = a;
    r.b[1] = m;
    r.b[2] = z;
    r.cnt  = 3'd3;
    return r;
  endfunction

  // Byte-order mark followed by a three-byte glyph.
  function automatic run_t run_glyph(input logic [7:0] t1, input logic [7:0] t2);
    run_t r;
    r      = RUN_NONE;
    r.b[0] = 8'hef;
    r.b[1] = 8'hbb;
    r.b[2] = 8'hbf;
    r.b[3] = 8'he2;
    r.b[4] = t1;
    r.b[5] = t2;
    r.cnt  = 3'd6;
    return r;
  endfunction

  function automatic run_t plain_rule(input logic [7:0] c);
    run_t r;
    case (c)
      CH_GRAVE: r = run_glyph(8'h80, 8'h92);
      CH_TILDE: r = run_glyph(8'h80, 8'hbe);
      CH_DEL:   r = run_glyph(8'h96, 8'h88);
      default:  r = (c >= CH_SPACE && c < 8'h80) ? run1(c) : run1(CH_QMARK);
    endcase
    return r;
  endfunction

  // Symbols after the accent prefix; unlisted bytes give an empty run.
  function automatic run_t sym_lookup(input logic [7:0] c);
    run_t r;
    case (c)
      8'h23:   r = run2(8'hc2, 8'ha3);
      8'h24:   r = run1(8'h24);
      8'h26:   r = run1(8'h23);
      8'h27:   r = run2(8'hc2, 8'ha7);
      8'h2c:   r = run3(8'he2, 8'h86, 8'h90);
      8'h2d:   r = run3(8'he2, 8'h86, 8'h91);
      8'h2e:   r = run3(8'he2, 8'h86, 8'h92);
      8'h2f:   r = run3(8'he2, 8'h86, 8'h93);
      8'h30:   r = run2(8'hc2, 8'hb0);
      8'h31:   r = run2(8'hc2, 8'hb1);
      8'h38:   r = run2(8'hc3, 8'hb7);
      8'h3c:   r = run2(8'hc2, 8'hbc);
      8'h3d:   r = run2(8'hc2, 8'hbd);
      8'h3e:   r = run2(8'hc2, 8'hbe);
      8'h6a:   r = run2(8'hc5, 8'h92);
      8'h7a:   r = run2(8'hc5, 8'h93);
      8'h7b:   r = run2(8'hc3, 8'h9f);
      default: r = RUN_NONE;
    endcase
    return r;
  endfunction

  // Second byte of an accented vowel; sel 0 grave, 1 acute, 2 circumflex, 3 diaeresis.
  // Returns 0 when c is not a vowel.
  function automatic logic [7:0] vowel_code(input logic [1:0] sel, input logic [7:0] c);
    logic [7:0] base;
    logic [7:0] off;
    case (c)
      "a":     base = 8'ha0;
      "e":     base = 8'ha8;
      "i":     base = 8'hac;
      "o":     base = 8'hb2;
      "u":     base = 8'hb9;
      "A":     base = 8'h80;
      "E":     base = 8'h88;
      "I":     base = 8'h8c;
      "O":     base = 8'h92;
      "U":     base = 8'h99;
      default: base = 8'h00;
    endcase
    case (sel)
      2'd0:    off = 8'd0;
      2'd1:    off = 8'd1;
      2'd2:    off = 8'd2;
      default: off = (c == "o" || c == "O") ? 8'd4 : 8'd3;
    endcase
    // The diaeresis on a, like on o, skips the tilde code point.
    if (sel == 2'd3 && (c == "a" || c == "A")) off = 8'd4;
    return (base == 8'h00) ? 8'h00 : base + off;
  endfunction

endpackage

// File: hw/rtl/legacy_charset_to_utf8_stream_unit.sv
// Top level: legacy 8-bit text to UTF-8 byte stream converter.
//
//  channel | direction | payload                    | handshake
//  in_     | input     | in_byte[7:0]               | in_valid / in_stall
//  out_    | output    | out_byte[7:0], last_of_run | out_valid / out_stall
//
// Each input byte is decoded in the cycle it is accepted and its run of
// zero to six UTF-8 bytes is loaded into a run register, then sent one byte
// a cycle while out_stall is low. While a run is being sent, input is stalled; the
// next transaction is taken in the cycle the last byte of the current run leaves.
// Bytes with no output (prefixes, skipped bytes, zero) load no run.
// Synchronous active-low reset returns the decode mode to normal and empties the run.
module legacy_charset_to_utf8_stream_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);
  import lc2u_pkg::*;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'd0,
    MODE_ACCENT = 4'd1,
    MODE_GRAVE  = 4'd2,
    MODE_ACUTE  = 4'd3,
    MODE_CIRC   = 4'd4,
    MODE_DIAER  = 4'd5,
    MODE_CEDIL  = 4'd6,
    MODE_ESC    = 4'd7,
    MODE_CUR1   = 4'd8,
    MODE_CUR2   = 4'd9
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  run_t                   dec;
  logic [RunMax-1:0][7:0] run_b_r;
  logic [2:0]             run_cnt_r;
  logic [2:0]             idx_r;
  logic                   run_vld_r;
  logic [3:0]             acc_diff;
  logic [7:0]             vcode;
  logic                   take, last, in_acc;

  assign acc_diff = 4'(mode_r) - 4'(MODE_GRAVE);
  assign vcode    = vowel_code(acc_diff[1:0], in_byte);

  always_comb begin
    dec      = RUN_NONE;
    mode_nxt = mode_r;
    if (in_byte == CH_NUL) begin
      mode_nxt = MODE_NORMAL;
    end else begin
      case (mode_r)
        MODE_ACCENT: begin
          case (in_byte)
            "A":     mode_nxt = MODE_GRAVE;
            "B":     mode_nxt = MODE_ACUTE;
            "C":     mode_nxt = MODE_CIRC;
            "H":     mode_nxt = MODE_DIAER;
            "K":     mode_nxt = MODE_CEDIL;
            default: begin
              mode_nxt = MODE_NORMAL;
              dec      = sym_lookup(in_byte);
            end
          endcase
        end
        MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_DIAER: begin
          mode_nxt = MODE_NORMAL;
          dec      = (vcode != 8'h00) ? run2(UTF_C3, vcode) : plain_rule(in_byte);
        end
        MODE_CEDIL: begin
          mode_nxt = MODE_NORMAL;
          if (in_byte == "c")      dec = run2(UTF_C3, 8'ha7);
          else if (in_byte == "C") dec = run2(UTF_C3, 8'h87);
          else                     dec = plain_rule(in_byte);
        end
        MODE_ESC: begin
          // Hold escape mode over space and hash, drop the next byte.
          if (in_byte != CH_SPACE && in_byte != CH_HASH) mode_nxt = MODE_NORMAL;
        end
        MODE_CUR1: mode_nxt = MODE_CUR2;
        MODE_CUR2: mode_nxt = MODE_NORMAL;
        default: begin
          mode_nxt = MODE_NORMAL;
          case (in_byte)
            CH_ACCENT: mode_nxt = MODE_ACCENT;
            CH_ESC:    mode_nxt = MODE_ESC;
            CH_CURSOR: mode_nxt = MODE_CUR1;
            default:   dec      = plain_rule(in_byte);
          endcase
        end
      endcase
    end
  end

  assign take     = run_vld_r && !out_stall;
  assign last     = (idx_r == run_cnt_r - 3'd1);
  assign in_stall = run_vld_r && !(take && last);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid       = run_vld_r;
  assign out_byte        = run_b_r[idx_r];
  assign out_last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      run_vld_r <= 1'b0;
      idx_r     <= 3'd0;
    end else begin
      if (in_acc) mode_r <= mode_nxt;
      // Load a fresh run over the one whose last byte is leaving.
      if (in_acc && dec.cnt != 3'd0) begin
        run_b_r   <= dec.b;
        run_cnt_r <= dec.cnt;
        idx_r     <= 3'd0;
        run_vld_r <= 1'b1;
      end else if (take) begin
        if (last) run_vld_r <= 1'b0;
        else      idx_r     <= idx_r + 3'd1;
      end
    end
  end

endmodule
